// ----- design/assert_macros.svh -----
// assertion helpers, clocked on clk and disabled while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define AFDS_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("afds assertion failed");

// next-cycle implication
`define AFDS_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("afds assertion failed");

`endif

// ----- design/afds_pkg.sv -----
package afds_pkg;

    localparam int FIELD_W    = 16;
    localparam int GAIN_W     = 16;
    localparam int AVG_W      = 32;
    localparam int PADDR_W    = 4;
    localparam int PDATA_W    = 32;
    localparam int MUL_CNT_W  = 4;
    localparam int DIV_DW     = 20;
    localparam int DIV_VW     = 10;
    localparam int DIV_STEP_W = 5;

    localparam logic [FIELD_W-1:0] MIN_DELAY_RST      = 16'd0;
    localparam logic [FIELD_W-1:0] GAIN_NORMAL_RST    = 16'd3277;
    localparam logic [FIELD_W-1:0] GAIN_EASY_DROP_RST = 16'd66;
    localparam logic [FIELD_W-1:0] GAIN_HIGH_RISE_RST = 16'd26214;
    localparam logic [FIELD_W-1:0] FIELD_MAX          = 16'hFFFF;

    localparam logic [MUL_CNT_W-1:0] MUL_LAST = 4'd15;

    // rounding divisor base and the two divider passes
    localparam logic [DIV_VW-1:0]     ROUND_BASE      = 10'd1000;
    localparam logic [DIV_DW-1:0]     ROUND_BASE_WIDE = 20'd1000;
    // 1000 placed in the top bits so a short pass leaves 1000 mod n
    localparam logic [DIV_DW-1:0]     ROUND_DIV_A     = 20'd1024000;
    localparam logic [DIV_STEP_W-1:0] STEPS_MOD       = 5'd10;
    localparam logic [DIV_STEP_W-1:0] STEPS_DIV       = 5'd20;

    typedef enum logic [1:0] {
        REG_MIN_DELAY,
        REG_GAIN_NORMAL,
        REG_GAIN_EASY_DROP,
        REG_GAIN_HIGH_RISE
    } reg_idx_t;

    typedef struct packed {
        logic                  start;
        logic [DIV_DW-1:0]     dividend;
        logic [DIV_VW-1:0]     divisor;
        logic [DIV_STEP_W-1:0] steps;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [DIV_DW-1:0] quotient;
        logic [DIV_VW-1:0] remainder;
    } div_res_t;

endpackage

// ----- design/afds_frame_if.sv -----
interface afds_frame_if;
    logic                           valid;
    logic                           ready;
    logic [afds_pkg::FIELD_W-1:0]   frame_time;

    modport source (output valid, output frame_time, input ready);
    modport sink (input valid, input frame_time, output ready);
endinterface

// ----- design/afds_result_if.sv -----
interface afds_result_if;
    logic                           valid;
    logic                           ready;
    logic [afds_pkg::FIELD_W-1:0]   wait_time;
    logic [afds_pkg::FIELD_W-1:0]   average_whole;

    modport source (output valid, output wait_time, output average_whole, input ready);
    modport sink (input valid, input wait_time, input average_whole, output ready);
endinterface

// ----- design/afds_div.sv -----
// restoring divider, one quotient bit per cycle
module afds_div (
    input  logic                clk,
    input  logic                rst_n,
    input  afds_pkg::div_req_t  req,
    output afds_pkg::div_res_t  res
);

    localparam int DW = afds_pkg::DIV_DW;
    localparam int VW = afds_pkg::DIV_VW;
    localparam int TW = afds_pkg::DIV_STEP_W;

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [TW-1:0] cnt_reg, cnt_next;
    logic [VW-1:0] rem_reg, rem_next;
    logic [DW-1:0] quo_reg, quo_next;
    logic [VW-1:0] dvs_reg, dvs_next;

    logic [VW:0]   shifted;
    logic [VW:0]   trial;

    assign shifted = {rem_reg, quo_reg[DW-1]};
    assign trial   = shifted - {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = req.steps;
            rem_next  = '0;
            quo_next  = req.dividend;
            dvs_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            // keep the trial difference when it does not go negative
            if (!trial[VW])
            begin
                rem_next = trial[VW-1:0];
                quo_next = {quo_reg[DW-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[VW-1:0];
                quo_next = {quo_reg[DW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - TW'(1);
            if (cnt_reg == TW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            rem_reg  <= '0;
            quo_reg  <= '0;
            dvs_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
            rem_reg  <= rem_next;
            quo_reg  <= quo_next;
            dvs_reg  <= dvs_next;
        end
    end

    assign res.done      = done_reg;
    assign res.quotient  = quo_reg;
    assign res.remainder = rem_reg;

endmodule

// ----- design/adaptive_frame_delay_smoother_unit.sv -----
// channel   dir   handshake      payload
// frame     in    valid/ready    frame_time [15:0]
// result    out   valid/ready    wait_time [15:0], average_whole [15:0]
// apb       in    psel/penable   paddr [3:0], pwdata [31:0], prdata [31:0]
//
// a request runs through prep, class, the gain multiply, update and check, then
// the two divider passes only when the new whole part lies in 1..1000, then fin
// the 16-step shift-add gain multiply and the two passes of the shared serial
// divider (10 and 20 steps) take the bulk of a request's time
// frame.ready is high only while the sequencer is idle
// a finished result waits in the output register; a stalled result holds the
// sequencer at its last step until the output register frees up
// rst_n clears the average and result.valid and returns the gains to their defaults
module adaptive_frame_delay_smoother_unit #(
    parameter int FRACTION_BITS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    afds_frame_if.sink                        frame,
    afds_result_if.source                     result,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [afds_pkg::PADDR_W-1:0]      paddr,
    input  logic [afds_pkg::PDATA_W-1:0]      pwdata,
    output logic [afds_pkg::PDATA_W-1:0]      prdata,
    output logic                              pready
);

    `include "assert_macros.svh"

    localparam int FW  = afds_pkg::FIELD_W;
    localparam int GW  = afds_pkg::GAIN_W;
    localparam int AW  = afds_pkg::AVG_W;
    localparam int PDW = afds_pkg::PDATA_W;
    localparam int CNW = afds_pkg::MUL_CNT_W;
    localparam int QW  = afds_pkg::DIV_DW;
    localparam int VW  = afds_pkg::DIV_VW;
    // sample in fixed point, then the widest of sample and average
    localparam int SW  = FW + FRACTION_BITS;
    localparam int DW  = (SW > AW) ? SW : AW;
    // gain product
    localparam int PW  = DW + GW;
    // room for 10*sample and 11*average
    localparam int CW  = (SW > AW) ? SW + 4 : AW + 4;

    // 15.0 in the average's format
    localparam logic [AW-1:0] AVG_FLOOR = {{(AW-4){1'b0}}, 4'd15} << FRACTION_BITS;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PREP,
        ST_CLASS,
        ST_MUL,
        ST_UPD,
        ST_CHK,
        ST_DIVA,
        ST_DIVB,
        ST_FIN
    } state_t;

    // configuration registers
    logic [FW-1:0] min_delay_reg;
    logic [FW-1:0] gain_normal_reg;
    logic [FW-1:0] gain_easy_drop_reg;
    logic [FW-1:0] gain_high_rise_reg;

    state_t         state_reg, state_next;
    logic [SW-1:0]  samp_reg, samp_next;
    logic [AW-1:0]  avg_reg, avg_next;
    logic [CW-1:0]  s10_reg, s10_next;
    logic [CW-1:0]  a11_reg, a11_next;
    logic [CW-1:0]  s4_reg, s4_next;
    logic [CW-1:0]  a3_reg, a3_next;
    logic [GW-1:0]  gain_reg, gain_next;
    logic           up_reg, up_next;
    logic [PW-1:0]  mcand_reg, mcand_next;
    logic [PW-1:0]  acc_reg, acc_next;
    logic [CNW-1:0] cnt_reg, cnt_next;
    logic [VW-1:0]  n10_reg, n10_next;
    logic [FW-1:0]  rounded_reg, rounded_next;
    logic           out_valid_reg, out_valid_next;
    logic [FW-1:0]  wait_reg, wait_next;
    logic [FW-1:0]  whole_reg, whole_next;

    logic [DW-1:0]  s_ext;
    logic [DW-1:0]  a_ext;
    logic           s_ge_a;
    logic           high_rise;
    logic           easy_drop;
    logic [GW-1:0]  gain_pick;
    logic [DW-1:0]  diff;
    logic [DW-1:0]  mag;
    logic [DW:0]    sum_up;
    logic [DW-1:0]  dif_dn;
    logic [AW-1:0]  avg_new;
    logic [AW-1:0]  n_whole;
    logic           n_zero;
    logic           n_big;
    logic [FW-1:0]  whole_sat;
    logic           cfg_wr;
    logic           out_free;

    afds_pkg::div_req_t div_req;
    afds_pkg::div_res_t div_res;

    // ---------------- configuration port ----------------
    assign cfg_wr = psel & penable & pwrite;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_delay_reg      <= afds_pkg::MIN_DELAY_RST;
            gain_normal_reg    <= afds_pkg::GAIN_NORMAL_RST;
            gain_easy_drop_reg <= afds_pkg::GAIN_EASY_DROP_RST;
            gain_high_rise_reg <= afds_pkg::GAIN_HIGH_RISE_RST;
        end
        else if (cfg_wr)
        begin
            unique case (afds_pkg::reg_idx_t'(paddr[3:2]))
                afds_pkg::REG_MIN_DELAY:      min_delay_reg      <= pwdata[FW-1:0];
                afds_pkg::REG_GAIN_NORMAL:    gain_normal_reg    <= pwdata[FW-1:0];
                afds_pkg::REG_GAIN_EASY_DROP: gain_easy_drop_reg <= pwdata[FW-1:0];
                afds_pkg::REG_GAIN_HIGH_RISE: gain_high_rise_reg <= pwdata[FW-1:0];
                default:                      ;
            endcase
        end
    end

    always_comb
    begin
        unique case (afds_pkg::reg_idx_t'(paddr[3:2]))
            afds_pkg::REG_MIN_DELAY:      prdata = PDW'(min_delay_reg);
            afds_pkg::REG_GAIN_NORMAL:    prdata = PDW'(gain_normal_reg);
            afds_pkg::REG_GAIN_EASY_DROP: prdata = PDW'(gain_easy_drop_reg);
            afds_pkg::REG_GAIN_HIGH_RISE: prdata = PDW'(gain_high_rise_reg);
            default:                      prdata = '0;
        endcase
    end

    // ---------------- datapath ----------------
    assign s_ext  = DW'(samp_reg);
    assign a_ext  = DW'(avg_reg);
    assign s_ge_a = s_ext >= a_ext;

    // sample above 1.1x average with average above 15
    assign high_rise = (s10_reg > a11_reg) && (avg_reg > AVG_FLOOR);
    // sample between 0.75x and 1.0x average
    assign easy_drop = !s_ge_a && (s4_reg > a3_reg);

    always_comb
    begin
        priority if (high_rise)
            gain_pick = gain_high_rise_reg;
        else if (easy_drop)
            gain_pick = gain_easy_drop_reg;
        else
            gain_pick = gain_normal_reg;
    end

    assign diff = s_ge_a ? (s_ext - a_ext) : (a_ext - s_ext);

    // step magnitude after the q0.16 gain
    assign mag    = acc_reg[PW-1:GW];
    assign sum_up = (DW+1)'(a_ext) + (DW+1)'(mag);
    assign dif_dn = a_ext - mag;

    always_comb
    begin
        if (up_reg)
            avg_new = (sum_up[DW:AW] != '0) ? '1 : sum_up[AW-1:0];
        else
            avg_new = (mag > a_ext) ? '0 : dif_dn[AW-1:0];
    end

    // integer part of the current average
    assign n_whole   = AW'(avg_reg[AW-1:FRACTION_BITS]);
    assign n_zero    = (n_whole == '0);
    assign n_big     = (n_whole > AW'(afds_pkg::ROUND_BASE));
    assign whole_sat = (n_whole > AW'(afds_pkg::FIELD_MAX)) ? afds_pkg::FIELD_MAX
                                                            : n_whole[FW-1:0];

    // shared divider: first 1000 mod n, then n*1000 / (1000 - rem)
    always_comb
    begin
        if (state_reg == ST_DIVA)
        begin
            div_req.start    = div_res.done;
            div_req.dividend = QW'(n10_reg) * afds_pkg::ROUND_BASE_WIDE;
            div_req.divisor  = afds_pkg::ROUND_BASE - div_res.remainder;
            div_req.steps    = afds_pkg::STEPS_DIV;
        end
        else
        begin
            div_req.start    = (state_reg == ST_CHK) && !n_zero && !n_big;
            div_req.dividend = afds_pkg::ROUND_DIV_A;
            div_req.divisor  = n_whole[VW-1:0];
            div_req.steps    = afds_pkg::STEPS_MOD;
        end
    end

    afds_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .res   (div_res)
    );

    assign out_free = !out_valid_reg || result.ready;

    // ---------------- sequencer ----------------
    always_comb
    begin
        state_next   = state_reg;
        samp_next    = samp_reg;
        avg_next     = avg_reg;
        s10_next     = s10_reg;
        a11_next     = a11_reg;
        s4_next      = s4_reg;
        a3_next      = a3_reg;
        gain_next    = gain_reg;
        up_next      = up_reg;
        mcand_next   = mcand_reg;
        acc_next     = acc_reg;
        cnt_next     = cnt_reg;
        n10_next     = n10_reg;
        rounded_next = rounded_reg;
        wait_next    = wait_reg;
        whole_next   = whole_reg;

        out_valid_next = out_valid_reg && !result.ready;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (frame.valid)
                begin
                    samp_next  = SW'(frame.frame_time) << FRACTION_BITS;
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                s10_next   = CW'(samp_reg) * CW'(10);
                a11_next   = CW'(avg_reg) * CW'(11);
                s4_next    = CW'(samp_reg) << 2;
                a3_next    = CW'(avg_reg) * CW'(3);
                state_next = ST_CLASS;
            end
            ST_CLASS:
            begin
                gain_next  = gain_pick;
                up_next    = s_ge_a;
                mcand_next = PW'(diff);
                // rounding bias so the downward step floors toward minus infinity
                acc_next   = s_ge_a ? '0 : PW'({GW{1'b1}});
                cnt_next   = '0;
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                if (gain_reg[0])
                    acc_next = acc_reg + mcand_reg;
                mcand_next = mcand_reg << 1;
                gain_next  = gain_reg >> 1;
                cnt_next   = cnt_reg + CNW'(1);
                if (cnt_reg == afds_pkg::MUL_LAST)
                    state_next = ST_UPD;
            end
            ST_UPD:
            begin
                avg_next   = avg_new;
                state_next = ST_CHK;
            end
            ST_CHK:
            begin
                n10_next = n_whole[VW-1:0];
                priority if (n_zero)
                begin
                    rounded_next = '0;
                    state_next   = ST_FIN;
                end
                else if (n_big)
                begin
                    rounded_next = afds_pkg::FIELD_MAX;
                    state_next   = ST_FIN;
                end
                else
                    state_next = ST_DIVA;
            end
            ST_DIVA:
            begin
                if (div_res.done)
                    state_next = ST_DIVB;
            end
            ST_DIVB:
            begin
                if (div_res.done)
                begin
                    rounded_next = div_res.quotient[FW-1:0];
                    state_next   = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    wait_next      = (rounded_reg > min_delay_reg) ?
                                     (rounded_reg - min_delay_reg) : '0;
                    whole_next     = whole_sat;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            samp_reg      <= '0;
            avg_reg       <= '0;
            s10_reg       <= '0;
            a11_reg       <= '0;
            s4_reg        <= '0;
            a3_reg        <= '0;
            gain_reg      <= '0;
            up_reg        <= 1'b0;
            mcand_reg     <= '0;
            acc_reg       <= '0;
            cnt_reg       <= '0;
            n10_reg       <= '0;
            rounded_reg   <= '0;
            out_valid_reg <= 1'b0;
            wait_reg      <= '0;
            whole_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            samp_reg      <= samp_next;
            avg_reg       <= avg_next;
            s10_reg       <= s10_next;
            a11_reg       <= a11_next;
            s4_reg        <= s4_next;
            a3_reg        <= a3_next;
            gain_reg      <= gain_next;
            up_reg        <= up_next;
            mcand_reg     <= mcand_next;
            acc_reg       <= acc_next;
            cnt_reg       <= cnt_next;
            n10_reg       <= n10_next;
            rounded_reg   <= rounded_next;
            out_valid_reg <= out_valid_next;
            wait_reg      <= wait_next;
            whole_reg     <= whole_next;
        end
    end

    assign frame.ready          = (state_reg == ST_IDLE);
    assign result.valid         = out_valid_reg;
    assign result.wait_time     = wait_reg;
    assign result.average_whole = whole_reg;

    // ---------------- checks ----------------
    // an accepted request takes the sequencer out of idle
    `AFDS_ASSERT_NXT(a_busy_after_accept, frame.valid && frame.ready, !frame.ready)
    // divider results only arrive while the sequencer waits for them
    `AFDS_ASSERT_IMP(a_div_done_wait, div_res.done, state_reg == ST_DIVA || state_reg == ST_DIVB)
    // a new result is only loaded from the final step
    `AFDS_ASSERT_IMP(a_result_from_fin, $rose(out_valid_reg), $past(state_reg) == ST_FIN)

endmodule
